/* rtl/core/lrumc_pkg.sv */
// Shared types and constants for the LRU cache miss counter.
// Used by lrumc_cell and lru_cache_miss_counter; depends on nothing.
package lrumc_pkg;

   localparam int CAP_BITS       = 5;
   localparam int COUNT_BITS     = 20;
   localparam int REQ_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 24;
   // rank field of the scan and update buses, wide enough for 64 ways
   localparam int BUS_RANK_BITS  = 6;

   localparam logic [CAP_BITS-1:0]   CAP_RESET = 5'd16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 20'hFFFFF;

   typedef enum logic [1:0] {
      UPD_HIT  = 2'd0,
      UPD_FILL = 2'd1,
      UPD_REPL = 2'd2
   } upd_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   // token passed cell to cell, one cell per cycle
   typedef struct packed {
      logic                     tok;
      logic                     hit;
      logic [BUS_RANK_BITS-1:0] hit_rank;
      logic                     free;
      logic [BUS_RANK_BITS-1:0] max_rank;
   } scan_type;

   // update broadcast to every cell
   typedef struct packed {
      logic                     commit;
      logic                     clear;
      upd_mode_type             mode;
      logic [BUS_RANK_BITS-1:0] ref_rank;
   } upd_type;

endpackage

/* rtl/core/lrumc_cell.sv */
// One cache way: key, valid bit and recency rank, plus one stage of the scan token.
// Uses types from lrumc_pkg.
module lrumc_cell #(
   parameter int WAYS     = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   active,
   input  logic [KEY_BITS-1:0]    key,
   input  lrumc_pkg::scan_type    scan_i,
   output lrumc_pkg::scan_type    scan_o,
   input  lrumc_pkg::upd_type     upd
);

   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic                 valid_ff, valid_in;
   logic [RANK_W-1:0]    rank_ff, rank_in;
   logic                 hit_mark_ff, hit_mark_in;
   logic                 free_mark_ff, free_mark_in;
   lrumc_pkg::scan_type  scan_ff, scan_in;

   logic [lrumc_pkg::BUS_RANK_BITS-1:0] rank_ext;
   logic match, empty, sel, younger;

   assign rank_ext = lrumc_pkg::BUS_RANK_BITS'(rank_ff);
   assign match    = active && valid_ff && (key_ff == key);
   assign empty    = active && !valid_ff;

   always_comb begin
      scan_in      = scan_i;
      hit_mark_in  = hit_mark_ff;
      free_mark_in = free_mark_ff;
      if (scan_i.tok) begin
         hit_mark_in  = match && !scan_i.hit;
         free_mark_in = empty && !scan_i.free;
         scan_in.hit  = scan_i.hit || match;
         scan_in.free = scan_i.free || empty;
         if (match && !scan_i.hit) begin
            scan_in.hit_rank = rank_ext;
         end
         if (active && (rank_ext > scan_i.max_rank)) begin
            scan_in.max_rank = rank_ext;
         end
      end
   end

   always_comb begin
      case (upd.mode)
         lrumc_pkg::UPD_HIT:  sel = hit_mark_ff;
         lrumc_pkg::UPD_FILL: sel = free_mark_ff;
         lrumc_pkg::UPD_REPL: sel = active && valid_ff && (rank_ext == upd.ref_rank);
         default:             sel = 1'b0;
      endcase
      younger = valid_ff && !sel &&
                ((upd.mode == lrumc_pkg::UPD_FILL) || (rank_ext < upd.ref_rank));
      key_in   = key_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd.commit) begin
         if (sel) begin
            key_in   = key;
            valid_in = 1'b1;
            rank_in  = '0;
         end else if (younger) begin
            rank_in = rank_ff + RANK_W'(1);
         end
         if (upd.clear) begin
            valid_in = 1'b0;
            rank_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         scan_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         scan_ff  <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      hit_mark_ff  <= hit_mark_in;
      free_mark_ff <= free_mark_in;
   end

   assign scan_o = scan_ff;

endmodule

/* rtl/core/lru_cache_miss_counter.sv */
// Top level of the LRU cache miss counter: control, miss count and the row of way cells.
// Depends on lrumc_pkg and lrumc_cell.
//
// Usage:
//   req_* carries one access per item: tdata holds the key, tlast marks the last
//   access of a run. rsp_* returns one item per access: hit flag, running miss
//   count (saturating) and tlast echoing the run end. csr_we/csr_wdata write the
//   number of active ways; write only while the block is idle.
//   A scan token walks the row of WAYS cells, one cell per cycle, gathering hit,
//   free way and oldest rank; the winning way is then updated in the commit state.
//   An accepted item passes start_ff, the cell row and res_ff before its commit
//   sets rsp_tvalid; a new item is taken only once the block is idle again.
//   A new item is accepted while the previous result still waits on rsp_tready;
//   a stalled result holds its commit until the output register frees up.
//   After a result with tlast the store and the miss count are cleared.
//   Reset empties all ways, clears the count and sets the active ways to 16.
module lru_cache_miss_counter #(
   parameter int WAYS     = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [lrumc_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // [15:0] access_key
   input  logic                                    req_tlast,  // last_access
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [lrumc_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,  // [0] was_hit, [20:1] miss_count
   output logic                                    rsp_tlast,  // run_done
   input  logic                                    csr_we,
   input  logic [lrumc_pkg::CAP_BITS-1:0]          csr_wdata   // ways_in_use
);

   lrumc_pkg::state_type state_ff, state_in;
   logic [lrumc_pkg::CAP_BITS-1:0]   cap_ff, cap_in;
   logic                             start_ff, start_in;
   logic [KEY_BITS-1:0]              key_ff, key_in;
   logic                             last_ff, last_in;
   lrumc_pkg::scan_type              res_ff, res_in;
   logic [lrumc_pkg::COUNT_BITS-1:0] miss_ff, miss_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic [lrumc_pkg::COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                             rsp_last_ff, rsp_last_in;

   lrumc_pkg::scan_type              head;
   lrumc_pkg::scan_type              chain [WAYS:0];
   lrumc_pkg::upd_type               upd;
   logic [WAYS-1:0]                  active;
   logic                             accept, out_free, commit;
   logic [lrumc_pkg::COUNT_BITS-1:0] miss_next;

   assign req_tready = (state_ff == lrumc_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == lrumc_pkg::ST_COMMIT) && out_free;

   always_comb begin
      head     = '0;
      head.tok = start_ff;
   end
   assign chain[0] = head;

   for (genvar g = 0; g < WAYS; g++) begin : g_way
      assign active[g] = (g == 0) || ({27'd0, cap_ff} > 32'(g));
      lrumc_cell #(
         .WAYS     (WAYS),
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .active (active[g]),
         .key    (key_ff),
         .scan_i (chain[g]),
         .scan_o (chain[g+1]),
         .upd    (upd)
      );
   end

   always_comb begin
      upd.commit = commit;
      upd.clear  = last_ff;
      if (res_ff.hit) begin
         upd.mode     = lrumc_pkg::UPD_HIT;
         upd.ref_rank = res_ff.hit_rank;
      end else if (res_ff.free) begin
         upd.mode     = lrumc_pkg::UPD_FILL;
         upd.ref_rank = res_ff.max_rank;
      end else begin
         upd.mode     = lrumc_pkg::UPD_REPL;
         upd.ref_rank = res_ff.max_rank;
      end
   end

   always_comb begin
      if (res_ff.hit || (miss_ff == lrumc_pkg::COUNT_MAX)) begin
         miss_next = miss_ff;
      end else begin
         miss_next = miss_ff + lrumc_pkg::COUNT_BITS'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      start_in     = accept;
      key_in       = accept ? KEY_BITS'(req_tdata) : key_ff;
      last_in      = accept ? req_tlast : last_ff;
      res_in       = res_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         lrumc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lrumc_pkg::ST_SCAN;
            end
         end
         lrumc_pkg::ST_SCAN: begin
            if (chain[WAYS].tok) begin
               res_in   = chain[WAYS];
               state_in = lrumc_pkg::ST_COMMIT;
            end
         end
         lrumc_pkg::ST_COMMIT: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_ff.hit;
               rsp_count_in = miss_next;
               rsp_last_in  = last_ff;
               miss_in      = last_ff ? '0 : miss_next;
               state_in     = lrumc_pkg::ST_IDLE;
            end
         end
         default: state_in = lrumc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrumc_pkg::ST_IDLE;
         cap_ff       <= lrumc_pkg::CAP_RESET;
         start_ff     <= 1'b0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         start_ff     <= start_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      last_ff      <= last_in;
      res_ff       <= res_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_hit_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit))
      else $error("result raised without a commit");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[WAYS].tok |-> (state_ff == lrumc_pkg::ST_SCAN))
      else $error("scan token left the row outside the scan state");

   a_run_clears_count: assert property (@(posedge clock) disable iff (reset)
      (commit && last_ff) |=> (miss_ff == '0))
      else $error("miss count not cleared after end of run");

endmodule
